// ===== rtl/asfvz_pkg.sv =====
`timescale 1ns / 1ps

package asfvz_pkg;

    localparam int ALT_W  = 28;
    localparam int TIME_W = 32;
    localparam int VEL_W  = 19;
    localparam int MAG_W  = ALT_W + 1;
    localparam int NUM_W  = MAG_W + 10;
    localparam int PROD_W = 24 + TIME_W;
    localparam int CNT_W  = 6;

    typedef logic [1:0] func_t;
    typedef logic [3:0] status_t;

    localparam func_t FUNC_SAMPLE  = 2'd0;
    localparam func_t FUNC_SEED    = 2'd1;
    localparam func_t FUNC_REBASE  = 2'd2;
    localparam func_t FUNC_SET_MAX = 2'd3;

    localparam status_t STAT_ACCEPTED   = 4'd0;
    localparam status_t STAT_NOT_READY  = 4'd1;
    localparam status_t STAT_BAD        = 4'd2;
    localparam status_t STAT_SPIKE      = 4'd3;
    localparam status_t STAT_RESEEDED   = 4'd4;
    localparam status_t STAT_SEEDED     = 4'd5;
    localparam status_t STAT_REBASED    = 4'd6;
    localparam status_t STAT_REBASE_REJ = 4'd7;
    localparam status_t STAT_MAX_SET    = 4'd8;

    localparam logic       CFG_MAX_RATE     = 1'b0;
    localparam logic       CFG_STREAK_LIMIT = 1'b1;
    localparam logic [23:0] MAX_RATE_RESET  = 24'd100000;
    localparam logic [7:0]  STREAK_RESET    = 8'd5;

    localparam logic signed [ALT_W-1:0] ALT_MIN_MM = -28'sd500000;
    localparam logic signed [ALT_W-1:0] ALT_MAX_MM = 28'sd50000000;
    localparam logic [NUM_W-1:0]        VZ_LIMIT   = 39'd200000;

    function automatic logic in_range(input logic signed [ALT_W-1:0] a);
        return (a >= ALT_MIN_MM) && (a <= ALT_MAX_MM);
    endfunction

endpackage

// ===== rtl/altitude_spike_filter_vz.sv =====
`timescale 1ns / 1ps
// Altitude spike filter with vertical-velocity differentiator.
// Input words arrive on s_*: tuser carries the item kind and the bad flag,
// tdata the altitude (mm) and the millisecond timestamp. Each input word
// gives exactly one result word on m_*: tuser carries the status, tdata the
// filtered altitude, the clamped vertical velocity and the maximum altitude.
// Registers are written on cfg_* (index 0 climb-rate threshold, index 1
// spike streak limit); the user must write them only while no word is in
// flight: the block itself does not enforce it. One word is processed at
// a time; s_tready is high only when idle. Each word passes the capture,
// difference, multiply and decide steps, the serial divider for an accepted
// sample that updates the velocity, and the finish step, where the result
// is loaded as s_tready returns. The rate test uses one 24x32 multiply in
// its own cycle. A result waits in the output register while m_tready is
// low; the block may take the next word meanwhile but holds its finish step
// until the output register is free. Reset (aresetn low, synchronous) clears
// the FSM and filter state, restores the register defaults and drops m_tvalid.
module altitude_spike_filter_vz (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // altitude_mm[27:0], time_ms[59:28], zero pad
    input  logic [2:0]  s_tuser,   // func[1:0], reading_bad[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // altitude_out_mm[27:0], vertical_velocity_mm_s[46:28],
                                   // max_altitude_mm[74:47], zero pad
    output logic [3:0]  m_tuser,   // status[3:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);
    import asfvz_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIFF, ST_MUL, ST_DECIDE, ST_DIV, ST_FINISH
    } state_t;

    state_t state_reg;

    func_t                    func_reg;
    logic signed [ALT_W-1:0]  alt_reg;
    logic [TIME_W-1:0]        time_reg;
    logic                     bad_reg;

    logic                     ready_reg;
    logic signed [ALT_W-1:0]  cur_alt_reg;
    logic signed [ALT_W-1:0]  prev_alt_reg;
    logic [TIME_W-1:0]        prev_time_reg;
    logic signed [VEL_W-1:0]  vel_reg;
    logic signed [ALT_W-1:0]  max_alt_reg;
    logic [7:0]               spike_cnt_reg;
    logic [23:0]              rate_reg;
    logic [7:0]               limit_reg;

    logic [TIME_W-1:0]        d_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [PROD_W-1:0]        prod_reg;
    status_t                  status_reg;
    logic                     div_start_reg;

    logic                     m_tvalid_reg;
    logic [79:0]              m_tdata_reg;
    status_t                  m_tuser_reg;

    logic signed [MAG_W-1:0]  diff;
    logic [NUM_W-1:0]         num_wide;
    logic                     spike;
    logic                     go_div;
    logic [7:0]               cnt_inc;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;
    logic [VEL_W-1:0]         vel_mag;
    logic                     out_free;

    assign diff     = MAG_W'(alt_reg) - MAG_W'(prev_alt_reg);
    assign num_wide = (NUM_W'(mag_reg) << 10) - (NUM_W'(mag_reg) << 4) - (NUM_W'(mag_reg) << 3);
    assign spike    = (d_reg != '0) && ({{(PROD_W-NUM_W){1'b0}}, num_reg} > prod_reg);
    assign go_div   = (func_reg == FUNC_SAMPLE) && ready_reg && !bad_reg &&
                      in_range(alt_reg) && !spike && (d_reg > TIME_W'(1));
    assign cnt_inc  = spike_cnt_reg + 8'd1;
    assign vel_mag  = (div_quo > VZ_LIMIT) ? VEL_W'(VZ_LIMIT) : div_quo[VEL_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    asfvz_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (num_reg),
        .den     (d_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            cur_alt_reg   <= '0;
            prev_alt_reg  <= '0;
            prev_time_reg <= '0;
            vel_reg       <= '0;
            max_alt_reg   <= '0;
            spike_cnt_reg <= '0;
            rate_reg      <= MAX_RATE_RESET;
            limit_reg     <= STREAK_RESET;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                if (cfg_index == CFG_MAX_RATE) begin
                    rate_reg <= cfg_data;
                end else begin
                    limit_reg <= cfg_data[7:0];
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= s_tuser[1:0];
                        bad_reg   <= s_tuser[2];
                        alt_reg   <= s_tdata[27:0];
                        time_reg  <= s_tdata[59:28];
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    d_reg     <= time_reg - prev_time_reg;
                    neg_reg   <= diff[MAG_W-1];
                    mag_reg   <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    num_reg   <= num_wide;
                    prod_reg  <= PROD_W'(rate_reg) * PROD_W'(d_reg);
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    state_reg     <= go_div ? ST_DIV : ST_FINISH;
                    div_start_reg <= go_div;
                    case (func_reg)
                        FUNC_SAMPLE: begin
                            if (!ready_reg) begin
                                status_reg <= STAT_NOT_READY;
                            end else if (bad_reg || !in_range(alt_reg)) begin
                                status_reg <= STAT_BAD;
                            end else if (spike) begin
                                if (cnt_inc >= limit_reg) begin
                                    spike_cnt_reg <= '0;
                                    cur_alt_reg   <= alt_reg;
                                    prev_alt_reg  <= alt_reg;
                                    prev_time_reg <= time_reg;
                                    vel_reg       <= '0;
                                    if (alt_reg > max_alt_reg) begin
                                        max_alt_reg <= alt_reg;
                                    end
                                    status_reg <= STAT_RESEEDED;
                                end else begin
                                    spike_cnt_reg <= cnt_inc;
                                    status_reg    <= STAT_SPIKE;
                                end
                            end else begin
                                spike_cnt_reg <= '0;
                                cur_alt_reg   <= alt_reg;
                                if (alt_reg > max_alt_reg) begin
                                    max_alt_reg <= alt_reg;
                                end
                                if (d_reg > TIME_W'(1)) begin
                                    prev_alt_reg  <= alt_reg;
                                    prev_time_reg <= time_reg;
                                end
                                status_reg <= STAT_ACCEPTED;
                            end
                        end
                        FUNC_SEED: begin
                            if (bad_reg) begin
                                ready_reg  <= 1'b0;
                                status_reg <= STAT_BAD;
                            end else begin
                                cur_alt_reg   <= alt_reg;
                                prev_alt_reg  <= alt_reg;
                                max_alt_reg   <= alt_reg;
                                prev_time_reg <= time_reg;
                                vel_reg       <= '0;
                                spike_cnt_reg <= '0;
                                ready_reg     <= 1'b1;
                                status_reg    <= STAT_SEEDED;
                            end
                        end
                        FUNC_REBASE: begin
                            if (bad_reg || !in_range(alt_reg)) begin
                                status_reg <= STAT_REBASE_REJ;
                            end else begin
                                cur_alt_reg   <= alt_reg;
                                prev_alt_reg  <= alt_reg;
                                prev_time_reg <= time_reg;
                                spike_cnt_reg <= '0;
                                status_reg    <= STAT_REBASED;
                            end
                        end
                        default: begin
                            max_alt_reg <= alt_reg;
                            status_reg  <= STAT_MAX_SET;
                        end
                    endcase
                end
                ST_DIV: begin
                    div_start_reg <= 1'b0;
                    if (div_done) begin
                        vel_reg   <= neg_reg ? VEL_W'(-vel_mag) : vel_mag;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {5'b0, max_alt_reg, vel_reg, cur_alt_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

endmodule

// ===== rtl/asfvz_div.sv =====
`timescale 1ns / 1ps

module asfvz_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [asfvz_pkg::NUM_W-1:0]  num,
    input  logic [asfvz_pkg::TIME_W-1:0] den,
    output logic                         done,
    output logic [asfvz_pkg::NUM_W-1:0]  quo
);
    import asfvz_pkg::*;

    logic [TIME_W-1:0] rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [TIME_W:0]   shifted;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= num;
                cnt_reg  <= CNT_W'(NUM_W);
                run_reg  <= 1'b1;
                done_reg <= 1'b0;
            end else if (run_reg) begin
                rem_reg <= fits ? TIME_W'(shifted - {1'b0, den}) : shifted[TIME_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg <= 1'b0;
                end
                done_reg <= (cnt_reg == CNT_W'(1));
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
